@@ hw/rtl/keyed_tone_controller_assert.svh @@
// Assertion macros for the keyed tone controller RTL.
// Needs clk and rst_n in the scope of each use.
`ifndef KEYED_TONE_CONTROLLER_ASSERT_SVH
`define KEYED_TONE_CONTROLLER_ASSERT_SVH

// same-cycle implication
`define KTC_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define KTC_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ hw/rtl/ktc_pkg.sv @@
// Shared types, constants and tone/melody tables for the keyed tone controller.
// No dependencies.
package ktc_pkg;

  localparam int STACK_DEPTH   = 8;
  localparam int MELODY_LENGTH = 10;

  localparam int STK_CNT_W = $clog2(STACK_DEPTH + 1);
  localparam int STK_PTR_W = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;
  localparam int MEL_IDX_W = 4;
  localparam int MEL_CNT_W = MEL_IDX_W + 1;

  localparam logic [2:0]  NO_NOTE  = 3'd7;
  localparam logic [10:0] HOLD_MAX = 11'd2047;

  localparam logic MODE_TICK  = 1'b0;
  localparam logic MODE_PRESS = 1'b1;

  localparam logic [3:0] CFG_DEBOUNCE = 4'd0;
  localparam logic [3:0] CFG_END_GAP  = 4'd1;

  localparam logic [9:0]  DEBOUNCE_RST = 10'd10;
  localparam logic [11:0] END_GAP_RST  = 12'd500;

  typedef struct packed {
    logic       push;
    logic       pop;
    logic [2:0] key;
  } stk_cmd_t;

  typedef struct packed {
    logic       empty;
    logic [2:0] top;
  } stk_status_t;

  typedef struct packed {
    logic [14:0] compare;
    logic [15:0] period;
  } tone_t;

  function automatic logic [15:0] note_period(input logic [2:0] n);
    logic [15:0] p;
    case (n)
      3'd0:    p = 16'd17200;
      3'd1:    p = 16'd15323;
      3'd2:    p = 16'd13652;
      3'd3:    p = 16'd12886;
      3'd4:    p = 16'd11479;
      3'd5:    p = 16'd10228;
      3'd6:    p = 16'd9111;
      default: p = 16'd0;
    endcase
    return p;
  endfunction

  function automatic logic [2:0] tune_note(input logic [MEL_IDX_W-1:0] i);
    logic [2:0] n;
    case (i)
      4'd0, 4'd3, 4'd9, 4'd10, 4'd13: n = 3'd0;
      4'd1, 4'd11:                    n = 3'd5;
      4'd2, 4'd6, 4'd8, 4'd12:        n = 3'd3;
      4'd4, 4'd7, 4'd14:              n = 3'd1;
      4'd5, 4'd15:                    n = 3'd2;
      default:                        n = 3'd0;
    endcase
    return n;
  endfunction

  function automatic logic [11:0] tune_time(input logic [MEL_IDX_W-1:0] i);
    logic [11:0] t;
    case (i)
      4'd4, 4'd5, 4'd6, 4'd8, 4'd14, 4'd15: t = 12'd500;
      4'd9:                                 t = 12'd1500;
      default:                              t = 12'd1000;
    endcase
    return t;
  endfunction

endpackage

@@ hw/rtl/ktc_stack.sv @@
// Bounded key stack: push on press beats, pop on debounced release.
// Depends on ktc_pkg and keyed_tone_controller_assert.svh.
`include "keyed_tone_controller_assert.svh"

module ktc_stack (
  input  logic                clk,
  input  logic                rst_n,
  input  ktc_pkg::stk_cmd_t   cmd,
  output ktc_pkg::stk_status_t status
);
  import ktc_pkg::*;

  logic [2:0]           stack_r [STACK_DEPTH];
  logic [STK_CNT_W-1:0] count_r;
  logic [STK_CNT_W-1:0] count_nxt;
  logic                 full;
  logic                 do_push;
  logic [STK_PTR_W-1:0] top_ptr;
  logic [STK_PTR_W-1:0] push_ptr;

  assign full     = (count_r == STK_CNT_W'(STACK_DEPTH));
  assign do_push  = cmd.push && (cmd.key != NO_NOTE) && !full;
  assign top_ptr  = STK_PTR_W'(count_r - 1'b1);
  assign push_ptr = STK_PTR_W'(count_r);

  always_comb begin
    count_nxt = count_r;
    if (do_push) begin
      count_nxt = count_r + 1'b1;
    end else if (cmd.pop && count_r != '0) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= '0;
    end else begin
      count_r <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      stack_r[push_ptr] <= cmd.key;
    end
  end

  assign status.empty = (count_r == '0);
  assign status.top   = stack_r[top_ptr];

  `KTC_ASSERT_NOW(a_count_bound, 1'b1, count_r <= STK_CNT_W'(STACK_DEPTH),
    "key stack count exceeds depth")
  `KTC_ASSERT_NEXT(a_push_grows, do_push, count_r == $past(count_r) + 1'b1,
    "push did not grow the key stack")

endmodule

@@ hw/rtl/ktc_engine.sv @@
// Tick engine: melody sequencer, key debounce and tone period/compare registers.
// Depends on ktc_pkg.
module ktc_engine (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 tick,
  input  logic [6:0]           key_levels,
  input  logic                 tune_select,
  input  logic [9:0]           debounce_ticks,
  input  logic [11:0]          end_gap_ticks,
  input  ktc_pkg::stk_status_t stk,
  output logic                 pop,
  output ktc_pkg::tone_t       tone
);
  import ktc_pkg::*;

  logic [2:0]           cur_note_r,  cur_note_nxt;
  logic                 stable_r,    stable_nxt;
  logic [10:0]          hold_r,      hold_nxt;
  logic [MEL_IDX_W-1:0] mel_idx_r,   mel_idx_nxt;
  logic [11:0]          mel_rem_r,   mel_rem_nxt;
  logic                 mel_gap_r,   mel_gap_nxt;
  logic [15:0]          period_r,    period_nxt;
  logic [14:0]          compare_r,   compare_nxt;

  logic [10:0]          hold_inc;
  logic [11:0]          rem_a;
  logic [11:0]          rem_b;
  logic                 gap_a;
  logic [MEL_CNT_W-1:0] idx_inc;
  logic [7:0]           levels_ext;
  logic                 released;
  logic [15:0]          per_sel;

  assign hold_inc   = (hold_r == HOLD_MAX) ? hold_r : hold_r + 1'b1;
  assign levels_ext = {1'b0, key_levels};
  assign released   = levels_ext[stk.top];
  assign idx_inc    = {1'b0, mel_idx_r} + 1'b1;

  always_comb begin
    cur_note_nxt = cur_note_r;
    stable_nxt   = stable_r;
    hold_nxt     = hold_r;
    mel_idx_nxt  = mel_idx_r;
    mel_rem_nxt  = mel_rem_r;
    mel_gap_nxt  = mel_gap_r;
    period_nxt   = period_r;
    compare_nxt  = compare_r;
    pop          = 1'b0;
    rem_a        = mel_rem_r;
    gap_a        = mel_gap_r;
    rem_b        = '0;
    per_sel      = '0;
    if (tick) begin
      hold_nxt = hold_inc;
      if (tune_select || mel_rem_r != '0) begin
        if (mel_rem_r == '0) begin
          per_sel     = note_period(tune_note(mel_idx_r));
          period_nxt  = per_sel;
          compare_nxt = per_sel[15:1];
          rem_a       = tune_time(mel_idx_r);
          gap_a       = 1'b0;
        end
        rem_b       = rem_a - 1'b1;
        mel_rem_nxt = rem_b;
        mel_gap_nxt = gap_a;
        if (rem_b == '0) begin
          if (gap_a) begin
            mel_gap_nxt = 1'b0;
          end else if (idx_inc >= MEL_CNT_W'(MELODY_LENGTH)) begin
            mel_idx_nxt = '0;
            compare_nxt = '0;
            mel_rem_nxt = end_gap_ticks;
            mel_gap_nxt = (end_gap_ticks != '0);
          end else begin
            mel_idx_nxt = idx_inc[MEL_IDX_W-1:0];
          end
        end
      end else begin
        compare_nxt = '0;
        if (!stk.empty) begin
          if (cur_note_r != stk.top) begin
            hold_nxt     = '0;
            cur_note_nxt = stk.top;
            stable_nxt   = 1'b0;
          end else if (stable_r && released) begin
            pop = 1'b1;
          end else if (hold_inc > {1'b0, debounce_ticks}) begin
            if (released) begin
              pop = 1'b1;
            end else begin
              stable_nxt  = 1'b1;
              per_sel     = note_period(cur_note_r);
              period_nxt  = per_sel;
              compare_nxt = per_sel[15:1];
            end
          end
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cur_note_r <= NO_NOTE;
      stable_r   <= 1'b0;
      hold_r     <= '0;
      mel_idx_r  <= '0;
      mel_rem_r  <= '0;
      mel_gap_r  <= 1'b0;
      period_r   <= '0;
      compare_r  <= '0;
    end else begin
      cur_note_r <= cur_note_nxt;
      stable_r   <= stable_nxt;
      hold_r     <= hold_nxt;
      mel_idx_r  <= mel_idx_nxt;
      mel_rem_r  <= mel_rem_nxt;
      mel_gap_r  <= mel_gap_nxt;
      period_r   <= period_nxt;
      compare_r  <= compare_nxt;
    end
  end

  assign tone.period  = period_r;
  assign tone.compare = compare_r;

endmodule

@@ hw/rtl/keyed_tone_controller.sv @@
// Keyed tone controller top level: stream ports, config registers, result handshake.
// Depends on ktc_pkg, ktc_stack, ktc_engine and keyed_tone_controller_assert.svh.
//
// One input beat is taken per clock unless stalled. A press beat (tuser = 1) pushes its
// key and gives no output beat; a tick beat (tuser = 0) gives exactly one output beat next
// cycle, holding the tone period and compare values after that tick. The engine's tone
// registers are the result register, so a new beat is taken whenever the output is empty
// or is taken in the same cycle; a stall on the output side stalls the input. No clearing
// pass after reset. Configuration writes are always accepted; unknown indexes are ignored.
`include "keyed_tone_controller_assert.svh"

module keyed_tone_controller (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [15:0] in_tdata,   // key[2:0], key_levels[9:3], tune_select[10], zero pad
  input  logic        in_tuser,   // mode: 0 tick, 1 key press
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [31:0] out_tdata,  // period[15:0], compare[30:16], zero pad
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [3:0]  cfg_addr,
  input  logic [11:0] cfg_data
);
  import ktc_pkg::*;

  logic        out_valid_r, out_valid_nxt;
  logic [9:0]  debounce_r;
  logic [11:0] end_gap_r;
  logic        in_beat;
  logic        tick;
  logic        pop;
  stk_cmd_t    stk_cmd;
  stk_status_t stk_status;
  tone_t       tone;

  assign cfg_ready = 1'b1;
  assign in_tready = !out_valid_r || out_tready;
  assign in_beat   = in_tvalid && in_tready;
  assign tick      = in_beat && (in_tuser == MODE_TICK);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      debounce_r <= DEBOUNCE_RST;
      end_gap_r  <= END_GAP_RST;
    end else if (cfg_valid) begin
      case (cfg_addr)
        CFG_DEBOUNCE: debounce_r <= cfg_data[9:0];
        CFG_END_GAP:  end_gap_r  <= cfg_data;
        default:      ;
      endcase
    end
  end

  assign stk_cmd.push = in_beat && (in_tuser == MODE_PRESS);
  assign stk_cmd.pop  = pop;
  assign stk_cmd.key  = in_tdata[2:0];

  ktc_stack u_stack (
    .clk    (clk),
    .rst_n  (rst_n),
    .cmd    (stk_cmd),
    .status (stk_status)
  );

  ktc_engine u_engine (
    .clk            (clk),
    .rst_n          (rst_n),
    .tick           (tick),
    .key_levels     (in_tdata[9:3]),
    .tune_select    (in_tdata[10]),
    .debounce_ticks (debounce_r),
    .end_gap_ticks  (end_gap_r),
    .stk            (stk_status),
    .pop            (pop),
    .tone           (tone)
  );

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (in_tready) begin
      out_valid_nxt = tick;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {1'b0, tone.compare, tone.period};

  `KTC_ASSERT_NEXT(a_tick_gives_beat, tick, out_tvalid, "tick beat gave no output beat")
  `KTC_ASSERT_NEXT(a_press_no_beat, in_beat && (in_tuser == MODE_PRESS), !out_tvalid,
    "press beat gave an output beat")
  `KTC_ASSERT_NOW(a_half_duty, out_tvalid,
    (tone.compare == '0) || (tone.compare == tone.period[15:1]),
    "compare is neither silent nor half the period")

endmodule

@@ dv/keyed_tone_controller_tb.sv @@
// Self-checking testbench for keyed_tone_controller: stream driver, result monitor, tone predictor.
// Depends on ktc_pkg and the keyed_tone_controller RTL; key sessions, melody soak, random noise.
module keyed_tone_controller_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import ktc_pkg::*;

  localparam int          CYCLE_LIMIT = 3_000_000;
  localparam logic [3:0]  CFG_SPARE   = 4'd15;
  localparam int          SOAK_TICKS  = 400;

  typedef struct packed {
    logic       mode;
    logic [2:0] key;
    logic [6:0] levels;
    logic       tune;
  } beat_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_tvalid = 1'b0;
  logic        in_tready;
  logic [15:0] in_tdata = '0;
  logic        in_tuser = 1'b0;
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [31:0] out_tdata;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [3:0]  cfg_addr = '0;
  logic [11:0] cfg_data = '0;

  keyed_tone_controller u_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_addr   (cfg_addr),
    .cfg_data   (cfg_data)
  );

  always #10 clk = ~clk;

  beat_t  beat_q[$];
  tone_t  tone_due_q[$];
  int     n_tick, n_press, n_tone, n_cfg, n_err;

  // predictor state
  logic [9:0]  db_lim   = DEBOUNCE_RST;
  logic [11:0] gap_len  = END_GAP_RST;
  logic [2:0]  key_stk [STACK_DEPTH];
  int unsigned stk_cnt  = 0;
  logic [2:0]  cur_note = NO_NOTE;
  bit          stable   = 1'b0;
  int unsigned hold_cnt = 0;
  int unsigned mel_idx  = 0;
  int unsigned mel_rem  = 0;
  bit          in_gap   = 1'b0;
  logic [15:0] per_r    = '0;
  logic [14:0] cmp_r    = '0;

  function automatic logic [15:0] pitch_of(input logic [2:0] n);
    case (n)
      3'd0:    return 16'd17200;
      3'd1:    return 16'd15323;
      3'd2:    return 16'd13652;
      3'd3:    return 16'd12886;
      3'd4:    return 16'd11479;
      3'd5:    return 16'd10228;
      3'd6:    return 16'd9111;
      default: return 16'd0;
    endcase
  endfunction

  function automatic logic [2:0] melody_note(input int unsigned i);
    logic [2:0] seq [16];
    seq = '{3'd0, 3'd5, 3'd3, 3'd0, 3'd1, 3'd2, 3'd3, 3'd1,
            3'd3, 3'd0, 3'd0, 3'd5, 3'd3, 3'd0, 3'd1, 3'd2};
    return seq[i % 16];
  endfunction

  function automatic int unsigned melody_len(input int unsigned i);
    int unsigned dur [16];
    dur = '{1000, 1000, 1000, 1000, 500, 500, 500, 1000,
            500, 1500, 1000, 1000, 1000, 1000, 500, 500};
    return dur[i % 16];
  endfunction

  function automatic void sound(input logic [2:0] n);
    per_r = pitch_of(n);
    cmp_r = per_r[15:1];
  endfunction

  function automatic void melody_step();
    if (mel_rem == 0) begin
      sound(melody_note(mel_idx));
      mel_rem = melody_len(mel_idx);
      in_gap  = 1'b0;
    end
    mel_rem--;
    if (mel_rem == 0) begin
      if (in_gap) begin
        in_gap = 1'b0;
      end else begin
        mel_idx++;
        if (mel_idx >= MELODY_LENGTH) begin
          mel_idx = 0;
          cmp_r   = '0;
          mel_rem = gap_len;
          in_gap  = (mel_rem != 0);
        end
      end
    end
  endfunction

  // debounce the top key and pop it on release; 1 when it is stable and pressed
  function automatic bit top_key_held(input logic [6:0] lv);
    logic [2:0] top;
    bit         rel;
    if (stk_cnt == 0) return 1'b0;
    top = key_stk[(stk_cnt - 1) % STACK_DEPTH];
    if (cur_note != top) begin
      hold_cnt = 0;
      cur_note = top;
      stable   = 1'b0;
      return 1'b0;
    end
    rel = lv[top];
    if (stable && rel) begin
      stk_cnt--;
      return 1'b0;
    end
    if (!(hold_cnt > db_lim)) return 1'b0;
    if (rel) begin
      stk_cnt--;
      return 1'b0;
    end
    stable = 1'b1;
    return 1'b1;
  endfunction

  function automatic bit next_tone(input beat_t b, output tone_t t);
    t = '0;
    if (b.mode == MODE_PRESS) begin
      if (b.key != NO_NOTE && stk_cnt < STACK_DEPTH) begin
        key_stk[stk_cnt] = b.key;
        stk_cnt++;
      end
      return 1'b0;
    end
    if (hold_cnt < HOLD_MAX) hold_cnt++;
    if (b.tune || mel_rem != 0) begin
      melody_step();
    end else if (top_key_held(b.levels) && cur_note != NO_NOTE) begin
      sound(cur_note);
    end else begin
      cmp_r = '0;
    end
    t.period  = per_r;
    t.compare = cmp_r;
    return 1'b1;
  endfunction

  // driver: bursts of beats with random gaps
  int burst_left = 0;
  int gap_left   = 0;
  beat_t cur_beat;

  always @(posedge clk) begin : drive_p
    tone_t t;
    bit    give;
    if (!rst_n) begin
      in_tvalid  <= 1'b0;
      burst_left = 0;
      gap_left   = 0;
    end else begin
      if (in_tvalid && in_tready) begin
        if (cur_beat.mode == MODE_PRESS) n_press++;
        else n_tick++;
        if (next_tone(cur_beat, t)) tone_due_q.push_back(t);
      end
      if (!in_tvalid || in_tready) begin
        give = 1'b0;
        if (gap_left != 0) begin
          gap_left--;
        end else if (beat_q.size() != 0) begin
          if (burst_left == 0) burst_left = $urandom_range(1, 48);
          cur_beat = beat_q.pop_front();
          give = 1'b1;
          burst_left--;
          if (burst_left == 0)
            gap_left = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 8);
        end
        in_tvalid <= give;
        if (give) begin
          in_tdata <= {5'd0, cur_beat.tune, cur_beat.levels, cur_beat.key};
          in_tuser <= cur_beat.mode;
        end
      end
    end
  end

  // monitor: result check and receiver stall pattern
  int st_mode = 0;
  int st_left = 0;

  always @(posedge clk) begin : check_p
    tone_t want, got;
    bit    rdy;
    if (!rst_n) begin
      out_tready <= 1'b0;
    end else begin
      if (out_tvalid && out_tready) begin
        got = out_tdata[30:0];
        if (tone_due_q.size() == 0) begin
          $display("%0t: unexpected tone beat period %0d compare %0d",
                   $time, got.period, got.compare);
          n_err++;
        end else begin
          want = tone_due_q.pop_front();
          if (got.period !== want.period) begin
            $display("%0t: tone beat %0d period expected %0d actual %0d",
                     $time, n_tone, want.period, got.period);
            n_err++;
          end
          if (got.compare !== want.compare) begin
            $display("%0t: tone beat %0d compare expected %0d actual %0d",
                     $time, n_tone, want.compare, got.compare);
            n_err++;
          end
        end
        n_tone++;
      end
      if (st_left == 0) begin
        st_mode = $urandom_range(0, 3);
        st_left = $urandom_range(16, 160);
      end
      st_left--;
      case (st_mode)
        0:       rdy = 1'b1;
        1:       rdy = ($urandom_range(0, 3) != 0);
        2:       rdy = 1'($urandom_range(0, 1));
        default: rdy = (st_left % 4 == 0);
      endcase
      out_tready <= rdy;
    end
  end

  // stimulus helpers
  task automatic add_beat(input logic mode, input logic [2:0] key, input logic [6:0] lv,
                          input logic tune);
    beat_t b;
    b.mode   = mode;
    b.key    = key;
    b.levels = lv;
    b.tune   = tune;
    beat_q.push_back(b);
  endtask

  task automatic add_tick(input logic [6:0] lv, input logic tune);
    add_beat(MODE_TICK, 3'($urandom), lv, tune);
  endtask

  task automatic add_press(input logic [2:0] key);
    add_beat(MODE_PRESS, key, 7'($urandom), 1'($urandom));
  endtask

  task automatic write_reg(input logic [3:0] idx, input logic [11:0] val);
    @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_addr  <= idx;
    cfg_data  <= val;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    n_cfg++;
    if (idx == CFG_DEBOUNCE) db_lim = val[9:0];
    else if (idx == CFG_END_GAP) gap_len = val;
  endtask

  task automatic wait_drained();
    while (beat_q.size() != 0 || in_tvalid || tone_due_q.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  // press a key, usually hold it past the debounce limit, bounce, then release
  task automatic add_session();
    logic [2:0] k;
    int         n;
    bit         never_down;
    k = 3'($urandom_range(0, 6));
    never_down = ($urandom_range(0, 7) == 0);
    add_press(k);
    if ($urandom_range(0, 4) == 0) add_press(3'($urandom_range(0, 7)));
    n = db_lim + $urandom_range(2, 6);
    repeat (n) begin
      if (never_down) add_tick(7'($urandom) | (7'd1 << k), 1'b0);
      else add_tick(7'($urandom) & ~(7'd1 << k), 1'b0);
    end
    repeat ($urandom_range(0, 3)) add_tick(7'($urandom), 1'b0);
    repeat ($urandom_range(1, 3)) add_tick(7'($urandom) | (7'd1 << k), 1'b0);
  endtask

  task automatic add_scenario();
    int r;
    r = $urandom_range(0, 39);
    if (r < 26) begin
      add_session();
    end else if (r < 34) begin
      repeat ($urandom_range(1, 12)) begin
        if ($urandom_range(0, 3) == 0) add_press(3'($urandom_range(0, 7)));
        else add_tick(7'($urandom), 1'b0);
      end
    end else if (r < 39) begin
      repeat ($urandom_range(1, 10)) add_press(3'($urandom_range(0, 7)));
    end else begin
      repeat ($urandom_range(1, 20)) add_tick(7'($urandom), 1'b0);
    end
  endtask

  // hold the tune switch for a stretch of the running note, presses mixed in
  task automatic add_soak();
    int n;
    n = 0;
    while (n < SOAK_TICKS) begin
      if ($urandom_range(0, 24) == 0) begin
        add_press(3'($urandom_range(0, 7)));
      end else begin
        add_tick(7'($urandom), 1'b1);
        n++;
      end
    end
  endtask

  initial begin : cycle_guard
    int cyc;
    cyc = 0;
    while (cyc < CYCLE_LIMIT) begin
      @(posedge clk);
      cyc++;
    end
    $display("%0t: timeout, %0d tone beats still due", $time, tone_due_q.size());
    $display("keyed_tone_controller: mismatch");
    $finish;
  end

  initial begin : stim
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    write_reg(CFG_DEBOUNCE, 12'd0);

    // directed: empty stack, invalid key, full stack, stable and unstable release, melody
    @(negedge clk);
    add_tick(7'h7F, 1'b0);
    add_tick(7'h00, 1'b0);
    add_press(NO_NOTE);
    add_tick(7'h00, 1'b0);
    for (int k = 0; k < 7; k++) add_press(3'(k));
    add_press(3'd6);
    add_press(3'd3);
    add_tick(7'h00, 1'b0);
    add_tick(7'h00, 1'b0);
    add_tick(7'h7F, 1'b0);
    add_tick(7'h7F, 1'b0);
    add_tick(7'h00, 1'b0);
    add_tick(7'h20, 1'b0);
    add_tick(7'h00, 1'b1);
    add_tick(7'h7F, 1'b0);
    add_press(3'd0);
    add_tick(7'h00, 1'b0);
    wait_drained();

    write_reg(CFG_SPARE, 12'($urandom));
    write_reg(CFG_DEBOUNCE, 12'($urandom_range(0, 12)));
    write_reg(CFG_END_GAP, 12'd4095);
    @(negedge clk);
    add_soak();
    wait_drained();
    // switch released: the note still plays out to its end
    @(negedge clk);
    repeat (mel_rem) add_tick(7'($urandom), 1'b0);

    for (int ph = 0; ph < 12; ph++) begin
      wait_drained();
      if ($urandom_range(0, 2) == 0) write_reg(CFG_SPARE, 12'($urandom));
      case (ph)
        2: begin
          write_reg(CFG_DEBOUNCE, 12'd40);
          @(negedge clk);
          add_session();
        end
        default: begin
          write_reg(CFG_DEBOUNCE, (ph == 0) ? 12'd0 : 12'($urandom_range(0, 12)));
          write_reg(CFG_END_GAP, 12'($urandom_range(0, 4095)));
          @(negedge clk);
          while (beat_q.size() < 52) add_scenario();
        end
      endcase
    end

    wait_drained();
    repeat (10) @(posedge clk);
    $display("covered %0d ticks and %0d key presses, %0d tone beats checked, %0d config writes",
             n_tick, n_press, n_tone, n_cfg);
    $display("first melody note played through with the switch held and released; debounce 0 to 40");
    if (n_err == 0) begin
      $display("keyed_tone_controller: match");
    end else begin
      $display("keyed_tone_controller: mismatch");
    end
    $finish;
  end

endmodule

@@ keyed_tone_controller.f @@
+incdir+hw/rtl
hw/rtl/ktc_pkg.sv
hw/rtl/ktc_stack.sv
hw/rtl/ktc_engine.sv
hw/rtl/keyed_tone_controller.sv
dv/keyed_tone_controller_tb.sv
